/* sv/sircd_pkg.sv */
// sircd_pkg: shared types, constants and the control program for the
// signed integer to radix digit converter. No dependencies.
`default_nettype none

package sircd_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int SYM_SLOTS      = 16;
    localparam int SYM_IDX_W      = 4;
    localparam int COUNT_W        = 5;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 5;
    localparam int DIV_CHUNK      = 8;
    localparam int DEF_MAX_SYMBOLS = 16;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int PC_W           = 4;

    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef enum logic [1:0] {
        REG_SYM_LO = 2'd0,
        REG_SYM_HI = 2'd1,
        REG_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CHK_INIT,
        OP_CHK_STEP,
        OP_DIV_STEP,
        OP_PUSH,
        OP_EMIT_SIGN,
        OP_EMIT_DIGIT,
        OP_EMIT_ERR
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_KNOWN,
        C_CHK_MORE,
        C_BAD,
        C_DIV_MORE,
        C_QUOT_NZ,
        C_NOT_NEG,
        C_OUT_BUSY,
        C_DIGIT_AGAIN
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic step;
        logic restart;
    } div_ctrl_t;

    typedef struct packed {
        logic more;
        logic quot_nz;
    } div_stat_t;

    // program step labels
    localparam logic [PC_W-1:0] ST_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] ST_CHK_TEST  = 4'd1;
    localparam logic [PC_W-1:0] ST_CHK_INIT  = 4'd2;
    localparam logic [PC_W-1:0] ST_CHK_LOOP  = 4'd3;
    localparam logic [PC_W-1:0] ST_BAD_TEST  = 4'd4;
    localparam logic [PC_W-1:0] ST_DIV       = 4'd5;
    localparam logic [PC_W-1:0] ST_PUSH      = 4'd6;
    localparam logic [PC_W-1:0] ST_SIGN_TEST = 4'd7;
    localparam logic [PC_W-1:0] ST_SIGN      = 4'd8;
    localparam logic [PC_W-1:0] ST_DIGIT     = 4'd9;
    localparam logic [PC_W-1:0] ST_DONE      = 4'd10;
    localparam logic [PC_W-1:0] ST_ERR       = 4'd11;
    localparam logic [PC_W-1:0] ST_ERR_DONE  = 4'd12;

    // control store: jump to target when the condition holds, else fall through
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_WAIT};
        unique case (pc)
            ST_WAIT:      w = '{op: OP_ACCEPT,     cond: C_NO_INPUT,    target: ST_WAIT};
            ST_CHK_TEST:  w = '{op: OP_NOP,        cond: C_KNOWN,       target: ST_BAD_TEST};
            ST_CHK_INIT:  w = '{op: OP_CHK_INIT,   cond: C_ALWAYS,      target: ST_CHK_LOOP};
            ST_CHK_LOOP:  w = '{op: OP_CHK_STEP,   cond: C_CHK_MORE,    target: ST_CHK_LOOP};
            ST_BAD_TEST:  w = '{op: OP_NOP,        cond: C_BAD,         target: ST_ERR};
            ST_DIV:       w = '{op: OP_DIV_STEP,   cond: C_DIV_MORE,    target: ST_DIV};
            ST_PUSH:      w = '{op: OP_PUSH,       cond: C_QUOT_NZ,     target: ST_DIV};
            ST_SIGN_TEST: w = '{op: OP_NOP,        cond: C_NOT_NEG,     target: ST_DIGIT};
            ST_SIGN:      w = '{op: OP_EMIT_SIGN,  cond: C_OUT_BUSY,    target: ST_SIGN};
            ST_DIGIT:     w = '{op: OP_EMIT_DIGIT, cond: C_DIGIT_AGAIN, target: ST_DIGIT};
            ST_DONE:      w = '{op: OP_NOP,        cond: C_ALWAYS,      target: ST_WAIT};
            ST_ERR:       w = '{op: OP_EMIT_ERR,   cond: C_OUT_BUSY,    target: ST_ERR};
            ST_ERR_DONE:  w = '{op: OP_NOP,        cond: C_ALWAYS,      target: ST_WAIT};
            default:      w = '{op: OP_NOP,        cond: C_ALWAYS,      target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/sircd_div.sv */
// sircd_div: restoring divider of a magnitude by a small radix, one byte of
// quotient bits per cycle while stepped. Depends on sircd_pkg.
`default_nettype none

module sircd_div
    import sircd_pkg::*;
#(
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire div_ctrl_t                      ctrl,
    input  wire logic [VALUE_BITS-1:0]          mag,
    input  wire logic [COUNT_W-1:0]             radix,
    output div_stat_t                           stat,
    output logic [$clog2(MAX_SYMBOLS)-1:0]      rem
);

    localparam int DIV_W     = ((VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK) * DIV_CHUNK;
    localparam int DIV_STEPS = DIV_W / DIV_CHUNK;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int DIG_W     = $clog2(MAX_SYMBOLS);
    localparam int CMP_W     = (DIG_W + 1 > COUNT_W) ? DIG_W + 1 : COUNT_W;

    logic [DIV_W-1:0] work_reg, work_next;
    logic [DIG_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // one chunk of quotient bits; the partial remainder stays below the radix
    always_comb
    begin
        logic [DIV_W-1:0] w;
        logic [DIG_W-1:0] r;
        logic [DIG_W:0]   t;
        w = work_reg;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < DIV_CHUNK; i++)
        begin
            t = {r, w[DIV_W-1]};
            w = {w[DIV_W-2:0], 1'b0};
            if (CMP_W'(t) >= CMP_W'(radix))
            begin
                t    = (DIG_W+1)'(CMP_W'(t) - CMP_W'(radix));
                w[0] = 1'b1;
            end
            r = t[DIG_W-1:0];
        end

        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load)
        begin
            work_next = DIV_W'(mag);
            rem_next  = '0;
            cnt_next  = '0;
        end
        else if (ctrl.step)
        begin
            work_next = w;
            rem_next  = r;
            cnt_next  = (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
        end
        else if (ctrl.restart)
        begin
            rem_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign stat.more    = (cnt_reg != CNT_W'(DIV_STEPS - 1));
    assign stat.quot_nz = |work_reg;
    assign rem          = rem_reg;

endmodule

`default_nettype wire

/* sv/signed_int_to_custom_radix_digits_top.sv */
// one value in flight at a time: after an accept the program checks the alphabet if needed,
// then runs the divider and pushes the digits one by one, emits a minus sign for a negative
// value and then the digits; output stalls delay the next accept
// the alphabet check runs once after a register write, on the next value
// rejected alphabet: one error transaction
// rst_n asynchronous, active low: control and configuration registers cleared, program at the wait step
`default_nettype none

// top level: register port, control sequencer, digit stack, output register.
// Depends on sircd_pkg and sircd_div.
module signed_int_to_custom_radix_digits_top
    import sircd_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [CHAR_W-1:0]     m_tdata,   // [7:0] character
    output logic                       m_tlast,   // last_of_run
    output logic                       m_tuser    // alphabet_invalid
);

    localparam int DIG_W = $clog2(MAX_SYMBOLS);
    localparam int SP_W  = $clog2(VALUE_BITS + 1);
    localparam int SPI_W = $clog2(VALUE_BITS);

    // configuration registers
    logic [CFG_DATA_W-1:0] sym_lo_reg, sym_hi_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  cfg_wr;

    // sequencer and datapath state
    logic [PC_W-1:0]      pc_reg, pc_next;
    logic                 known_reg, known_next;
    logic                 bad_reg, bad_next;
    logic [SYM_IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic                 neg_reg, neg_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [DIG_W-1:0]     stack_reg [VALUE_BITS];
    logic                 push_en;

    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_user_reg, m_user_next;

    logic [CHAR_W-1:0]    syms [SYM_SLOTS];
    logic [CHAR_W-1:0]    chk_sym;
    logic                 chk_hit, chk_bad, chk_last, chk_more;
    logic [SP_W-1:0]      sp_m1;
    logic [DIG_W-1:0]     top_digit;
    logic                 out_busy, out_free, accept, take;
    logic [VALUE_BITS-1:0] raw, mag;
    uword_t               uw;
    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;
    logic [DIG_W-1:0]     div_rem;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[4:3]))
            REG_SYM_LO: prdata = sym_lo_reg;
            REG_SYM_HI: prdata = sym_hi_reg;
            REG_COUNT:  prdata = CFG_DATA_W'(count_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
            count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_t'(paddr[4:3]))
                REG_SYM_LO: sym_lo_reg <= pwdata;
                REG_SYM_HI: sym_hi_reg <= pwdata;
                REG_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < SYM_SLOTS / 2; i++)
        begin
            syms[i]                 = sym_lo_reg[i*CHAR_W +: CHAR_W];
            syms[i + SYM_SLOTS / 2] = sym_hi_reg[i*CHAR_W +: CHAR_W];
        end
    end

    // alphabet check: symbol at chk_idx against every earlier one and the signs
    always_comb
    begin
        chk_sym = syms[chk_idx_reg];
        chk_hit = (chk_sym == PLUS_CHAR) || (chk_sym == MINUS_CHAR);
        for (int j = 0; j < SYM_SLOTS; j++)
        begin
            if ((SYM_IDX_W'(j) < chk_idx_reg) && (syms[j] == chk_sym))
            begin
                chk_hit = 1'b1;
            end
        end
        chk_bad  = bad_reg || chk_hit;
        chk_last = ({1'b0, chk_idx_reg} == count_reg - 1'b1);
        chk_more = !chk_bad && !chk_last;
    end

    assign raw = s_tdata[VALUE_BITS-1:0];
    assign mag = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;

    assign uw        = ucode_rom(pc_reg);
    assign out_busy  = m_valid_reg && !m_tready;
    assign out_free  = !out_busy;
    assign s_tready  = (uw.op == OP_ACCEPT);
    assign accept    = s_tvalid && s_tready;
    assign sp_m1     = sp_reg - 1'b1;
    assign top_digit = stack_reg[sp_m1[SPI_W-1:0]];

    assign div_ctrl.load    = accept;
    assign div_ctrl.step    = (uw.op == OP_DIV_STEP);
    assign div_ctrl.restart = (uw.op == OP_PUSH);

    sircd_div #(
        .VALUE_BITS  (VALUE_BITS),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .mag   (mag),
        .radix (count_reg),
        .stat  (div_stat),
        .rem   (div_rem)
    );

    always_comb
    begin
        unique case (uw.cond)
            C_ALWAYS:      take = 1'b1;
            C_NO_INPUT:    take = !s_tvalid;
            C_KNOWN:       take = known_reg;
            C_CHK_MORE:    take = chk_more;
            C_BAD:         take = bad_reg;
            C_DIV_MORE:    take = div_stat.more;
            C_QUOT_NZ:     take = div_stat.quot_nz;
            C_NOT_NEG:     take = !neg_reg;
            C_OUT_BUSY:    take = out_busy;
            C_DIGIT_AGAIN: take = out_busy || (sp_reg != SP_W'(1));
            default:       take = 1'b0;
        endcase
        pc_next = take ? uw.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        known_next   = known_reg;
        bad_next     = bad_reg;
        chk_idx_next = chk_idx_reg;
        neg_next     = neg_reg;
        sp_next      = sp_reg;
        push_en      = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        unique case (uw.op)
            OP_NOP:
            begin
            end
            OP_ACCEPT:
            begin
                if (accept)
                begin
                    neg_next = raw[VALUE_BITS-1];
                end
            end
            OP_CHK_INIT:
            begin
                chk_idx_next = '0;
                bad_next     = (count_reg < COUNT_W'(2)) ||
                               (count_reg > COUNT_W'(MAX_SYMBOLS));
            end
            OP_CHK_STEP:
            begin
                bad_next     = chk_bad;
                chk_idx_next = chk_idx_reg + 1'b1;
                if (!chk_more)
                begin
                    known_next = 1'b1;
                end
            end
            OP_DIV_STEP:
            begin
            end
            OP_PUSH:
            begin
                push_en = 1'b1;
                sp_next = sp_reg + 1'b1;
            end
            OP_EMIT_SIGN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = MINUS_CHAR;
                    m_last_next  = 1'b0;
                    m_user_next  = 1'b0;
                end
            end
            OP_EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = syms[SYM_IDX_W'(top_digit)];
                    m_last_next  = (sp_reg == SP_W'(1));
                    m_user_next  = 1'b0;
                    sp_next      = sp_m1;
                end
            end
            OP_EMIT_ERR:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    m_user_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // any register write invalidates the cached alphabet verdict
        if (cfg_wr)
        begin
            known_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= ST_WAIT;
            known_reg   <= 1'b0;
            bad_reg     <= 1'b0;
            chk_idx_reg <= '0;
            neg_reg     <= 1'b0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            known_reg   <= known_next;
            bad_reg     <= bad_next;
            chk_idx_reg <= chk_idx_next;
            neg_reg     <= neg_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
        if (push_en)
        begin
            stack_reg[sp_reg[SPI_W-1:0]] <= div_rem;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    // a new value is only taken with the digit stack drained
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (sp_reg == '0))
        else $error("input taken with digits still stacked");

    // one value at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second value accepted back to back");

    // the error transaction always closes its run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("error transaction without last or with data");

    // digit stack never grows past the widest digit string
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_PUSH) |-> (sp_reg < SP_W'(VALUE_BITS)))
        else $error("digit stack overflow");
`endif

endmodule

`default_nettype wire

/* sim/signed_int_to_custom_radix_digits_top_tb.sv */
// testbench for signed_int_to_custom_radix_digits_top: converts signed values through
// random and hand-picked alphabets and checks every character against a local predictor.
// Depends on sircd_pkg and the top level with its submodules.
`timescale 1ns / 100ps

module signed_int_to_custom_radix_digits_top_tb;
    import sircd_pkg::*;

    localparam int  MAX_CYCLES     = 1_000_000;
    localparam int  LONG_HOLD      = 400;
    localparam int  RANDOM_PHASES  = 12;
    localparam int  VALUES_PER_SET = 40;
    localparam int  UNUSED_REG_IDX = 3;
    localparam int  SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_of_run;
        logic              alphabet_invalid;
    } char_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata;    // [31:0] value
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CHAR_W-1:0]     m_tdata;    // [7:0] character
    logic                  m_tlast;    // last_of_run
    logic                  m_tuser;    // alphabet_invalid

    // local copy of the register file
    logic [CFG_DATA_W-1:0] alpha_lo;
    logic [CFG_DATA_W-1:0] alpha_hi;
    logic [COUNT_W-1:0]    alpha_count;

    logic [VALUE_W-1:0] value_queue[$];
    char_item_t         pending_chars[$];

    int  cycle_count;
    int  mismatch_count;
    int  values_sent;
    int  chars_checked;
    int  rejected_runs;
    int  alphabet_sets;
    logic in_hs;
    int  send_gap;
    int  ready_gap;
    int  hold_left;
    bit  send_idle;
    bit  recv_idle;
    bit  long_hold_go;
    bit  hold_served;

    signed_int_to_custom_radix_digits_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CHAR_W-1:0] symbol_at(input int idx);
        if (idx < 8)
            return alpha_lo[8*idx +: 8];
        return alpha_hi[8*(idx-8) +: 8];
    endfunction

    function automatic bit alphabet_usable();
        bit [255:0]        seen;
        logic [CHAR_W-1:0] sym;
        seen = '0;
        if (alpha_count < 2 || alpha_count > SYM_SLOTS)
            return 1'b0;
        for (int i = 0; i < alpha_count; i++)
        begin
            sym = symbol_at(i);
            if (seen[sym] || sym == PLUS_CHAR || sym == MINUS_CHAR)
                return 1'b0;
            seen[sym] = 1'b1;
        end
        return 1'b1;
    endfunction

    // expected characters of one value, most significant digit first
    function automatic void convert_to_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  digs[VALUE_W];
        logic               negative;
        int                 nd;
        nd = 0;
        if (!alphabet_usable())
        begin
            pending_chars.push_back('{character: '0, last_of_run: 1'b1, alphabet_invalid: 1'b1});
            return;
        end
        negative = value[VALUE_W-1];
        // the most negative value wraps to its own unsigned magnitude
        mag = negative ? (~value + 1'b1) : value;
        do
        begin
            digs[nd] = symbol_at(int'(mag % alpha_count));
            nd++;
            mag = mag / alpha_count;
        end
        while (mag != 0);
        if (negative)
            pending_chars.push_back('{character: MINUS_CHAR, last_of_run: 1'b0,
                                      alphabet_invalid: 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            pending_chars.push_back('{character: digs[i], last_of_run: (i == 0),
                                      alphabet_invalid: 1'b0});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // input and output monitor
    always @(posedge clk)
    begin
        char_item_t want;
        in_hs <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            convert_to_digits(s_tdata);
            values_sent++;
        end
        if (m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected character %02h", m_tdata));
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (want.alphabet_invalid)
                    rejected_runs++;
                if (m_tdata !== want.character)
                    report_mismatch($sformatf("character %02h, wanted %02h",
                                              m_tdata, want.character));
                if (m_tlast !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, wanted %b",
                                              m_tlast, want.last_of_run));
                if (m_tuser !== want.alphabet_invalid)
                    report_mismatch($sformatf("alphabet_invalid %b, wanted %b",
                                              m_tuser, want.alphabet_invalid));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, pending_chars.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // value driver
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_hs))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (value_queue.size() > 0 && send_idle && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end
            else if (value_queue.size() > 0)
            begin
                s_tdata  <= value_queue.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // character receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_go && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left   = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 7) == 0)
            begin
                ready_gap = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_SYM_LO: alpha_lo    = data;
            REG_SYM_HI: alpha_hi    = data;
            REG_COUNT:  alpha_count = data[COUNT_W-1:0];
            default:    ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(posedge clk);
        #1;
    endtask

    // block is idle: no value left to offer and every character back
    task automatic settle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (value_queue.size() != 0 || s_tvalid || pending_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        #1;
    endtask

    task automatic load_alphabet(input logic [CFG_DATA_W-1:0] lo,
                                 input logic [CFG_DATA_W-1:0] hi,
                                 input logic [CFG_DATA_W-1:0] count_word);
        settle();
        apb_write(REG_SYM_LO, lo);
        apb_write(REG_SYM_HI, hi);
        apb_write(REG_COUNT, count_word);
        alphabet_sets++;
    endtask

    task automatic random_alphabet();
        logic [CHAR_W-1:0]     syms[SYM_SLOTS];
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        bit [255:0]            used;
        int                    cnt;
        int                    j;
        int                    k;
        used = '0;
        used[PLUS_CHAR]  = 1'b1;
        used[MINUS_CHAR] = 1'b1;
        case ($urandom_range(0, 9))
            0:       cnt = 2;
            1:       cnt = SYM_SLOTS;
            default: cnt = $urandom_range(2, SYM_SLOTS);
        endcase
        for (int i = 0; i < SYM_SLOTS; i++)
        begin
            syms[i] = 8'($urandom_range(0, 255));
            if (i < cnt)
            begin
                while (used[syms[i]])
                    syms[i] = 8'($urandom_range(0, 255));
                used[syms[i]] = 1'b1;
            end
        end
        // a quarter of the settings are broken on purpose
        if ($urandom_range(0, 3) == 0)
        begin
            j = $urandom_range(0, cnt - 1);
            k = (j + $urandom_range(1, cnt - 1)) % cnt;
            case ($urandom_range(0, 3))
                0: syms[j] = syms[k];
                1: syms[j] = PLUS_CHAR;
                2: syms[j] = MINUS_CHAR;
                default: cnt = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                    : $urandom_range(SYM_SLOTS + 1, 31);
            endcase
        end
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = syms[i];
            hi[8*i +: 8] = syms[i+8];
        end
        load_alphabet(lo, hi, {$urandom, $urandom} & ~64'h1F | cnt);
        if ($urandom_range(0, 3) == 0)
            apb_write(2'(UNUSED_REG_IDX), {$urandom, $urandom});
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        longint pw;
        longint v;
        int     radix;
        int     n;
        radix = (alpha_count < 2 || alpha_count > SYM_SLOTS) ? 2 : alpha_count;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4:          v = $urandom_range(0, 40) - 20;
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            6, 7:
            begin
                // around a power of the radix, where the digit count changes
                pw = 1;
                n = $urandom_range(1, 31);
                for (int i = 0; i < n && pw * radix <= 64'h8000_0000; i++)
                    pw = pw * radix;
                v = pw - $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:    v = $urandom_range(0, 100000) - 50000;
        endcase
        return v[VALUE_W-1:0];
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        alpha_lo     = '0;
        alpha_hi     = '0;
        alpha_count  = '0;
        in_hs        = 1'b0;
        send_gap     = 0;
        ready_gap    = 0;
        hold_left    = 0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        long_hold_go = 1'b0;
        hold_served  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        #1;

        // registers still at reset: count of zero rejects the alphabet
        value_queue.push_back(32'd5);

        // decimal digits
        load_alphabet(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938, 64'd10);
        value_queue.push_back(32'd0);
        value_queue.push_back(32'd1);
        value_queue.push_back(32'hFFFF_FFFF);
        value_queue.push_back(32'h7FFF_FFFF);
        value_queue.push_back(32'h8000_0000);
        value_queue.push_back(32'd12345);
        value_queue.push_back(-32'sd9);

        // sixteen raw byte symbols, zero byte among them
        load_alphabet(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 64'd16);
        value_queue.push_back(32'd0);
        value_queue.push_back(32'h8000_0000);
        value_queue.push_back(32'h7FFF_FFFF);
        value_queue.push_back(32'hDEAD_BEEF);

        // binary, unused bytes hold a duplicate and both signs
        load_alphabet(64'h2D2B_6161_2D2B_6261, 64'h2B2D_6161_2B2D_6161, 64'd2);
        apb_write(2'(UNUSED_REG_IDX), 64'hFFFF_FFFF_FFFF_FFFF);
        value_queue.push_back(32'h8000_0000);
        value_queue.push_back(32'hFFFF_FFFF);
        value_queue.push_back(32'h7FFF_FFFF);

        // rejected alphabets: repeat, plus, minus, count too large, count of one
        load_alphabet(64'h0000_0000_0078_7978, 64'h0, 64'd3);
        value_queue.push_back(32'd77);
        load_alphabet(64'h0000_0000_0033_2B31, 64'h0, 64'd3);
        value_queue.push_back(32'hFFFF_FF00);
        load_alphabet(64'h0000_0000_2D32_3130, 64'h0, 64'd4);
        value_queue.push_back(32'd1);
        load_alphabet(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 64'd17);
        value_queue.push_back(32'd100);
        settle();
        apb_write(REG_COUNT, 64'd31);
        value_queue.push_back(32'h8000_0000);
        settle();
        apb_write(REG_COUNT, 64'hFFFF_FFFF_FFFF_FFE1);
        value_queue.push_back(32'd0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_alphabet();
            // no idling toward the end of the run
            send_idle = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            recv_idle = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            // receiver stalls long while values keep coming
            if (p == 2)
                long_hold_go = 1'b1;
            for (int i = 0; i < VALUES_PER_SET; i++)
                value_queue.push_back(random_value());
        end

        settle();
        repeat (50) @(posedge clk);
        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        $display("converted %0d values into %0d characters over %0d alphabet settings",
                 values_sent, chars_checked, alphabet_sets);
        $display("%0d rejected-alphabet runs, %0d mismatches", rejected_runs, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
sv/sircd_pkg.sv
sv/sircd_div.sv
sv/signed_int_to_custom_radix_digits_top.sv
sim/signed_int_to_custom_radix_digits_top_tb.sv
